@@ hdl/atc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atc_pkg: shared types and constants of the accelerometer tilt calibrator
// Holds the fixed field widths, register index codes, reset values, and the
// CORDIC arctangent table used by the calibration and angle pipelines.
// ----------------------------------------------------------------------------
package atc_pkg;

   localparam int DEF_SAMPLE_BITS  = 16;
   localparam int DEF_ANGLE_STAGES = 16;

   // Calibrated axis format, Q2.13.
   localparam int NORM_W     = 16;
   localparam int NORM_SHIFT = 13;
   localparam int NORM_HALF  = 2 ** (NORM_W - 1);
   localparam int NORM_MAX   = NORM_HALF - 1;

   // Normalizer latency: input stage, magnitude stage, NORM_W + 1 quotient
   // steps and the saturation stage.
   localparam int NORM_LAT = NORM_W + 4;

   // Magnitude path: square, sum and one root bit per step.
   localparam int SQ_W       = 2 * NORM_W;
   localparam int SQRT_STEPS = NORM_W;
   localparam int SQ_LAT     = SQRT_STEPS + 2;

   // CORDIC formats.
   localparam int CIN_W        = NORM_W + 2;
   localparam int GAIN_SHIFT   = 24;
   localparam int CORDIC_W     = 44;
   localparam int ANG_W        = 33;
   localparam int ANGLE_DROP   = 16;
   localparam int ARC_LEN      = 24;
   localparam int QUARTER_TURN = 754974720;

   localparam int PITCH_W     = 16;
   localparam int ROLL_W      = 15;
   localparam int PITCH_LIMIT = 23040;
   localparam int ROLL_LIMIT  = 11520;

   // Configuration registers.
   localparam int CSR_INDEX_W   = 3;
   localparam int REF_NEG_RESET = -16384;
   localparam int REF_POS_RESET = 16384;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_NEG = 3'd0,
      CSR_X_POS = 3'd1,
      CSR_Y_NEG = 3'd2,
      CSR_Y_POS = 3'd3,
      CSR_Z_NEG = 3'd4,
      CSR_Z_POS = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic signed [NORM_W-1:0] z;
      logic                     fault;
   } norm_set_type;

   // atan(2^-i) in units of 2^-23 degree.
   function automatic logic signed [ANG_W-1:0] arc_angle(input int idx);
      logic signed [ANG_W-1:0] a;
      case (idx)
         0:  a = ANG_W'(377487360);
         1:  a = ANG_W'(222843801);
         2:  a = ANG_W'(117744544);
         3:  a = ANG_W'(59768969);
         4:  a = ANG_W'(30000467);
         5:  a = ANG_W'(15014858);
         6:  a = ANG_W'(7509261);
         7:  a = ANG_W'(3754860);
         8:  a = ANG_W'(1877459);
         9:  a = ANG_W'(938733);
         10: a = ANG_W'(469367);
         11: a = ANG_W'(234683);
         12: a = ANG_W'(117342);
         13: a = ANG_W'(58671);
         14: a = ANG_W'(29335);
         15: a = ANG_W'(14668);
         16: a = ANG_W'(7334);
         17: a = ANG_W'(3667);
         18: a = ANG_W'(1833);
         19: a = ANG_W'(917);
         20: a = ANG_W'(458);
         21: a = ANG_W'(229);
         22: a = ANG_W'(115);
         23: a = ANG_W'(57);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

@@ hdl/atc_norm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atc_norm: two-point calibration of one axis
// Computes round((2*raw - neg - pos) * 8192 / (pos - neg)) with a restoring
// divider that resolves one quotient bit per stage, then saturates to Q2.13.
// ----------------------------------------------------------------------------
module atc_norm import atc_pkg::*; #(
   parameter int REF_W = DEF_SAMPLE_BITS
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   input  wire  signed [REF_W-1:0]  raw,
   input  wire  signed [REF_W-1:0]  neg_ref,
   input  wire  signed [REF_W-1:0]  pos_ref,
   output logic                     out_valid,
   output logic signed [NORM_W-1:0] norm,
   output logic                     fault
);

   localparam int D_W   = REF_W + 2;
   localparam int DEN_W = REF_W + 1;
   localparam int N_W   = REF_W + 17;
   localparam int REM_W = REF_W + 18;
   localparam int Q_W   = NORM_W + 1;
   localparam int STEPS = Q_W;

   logic signed [D_W-1:0]   diff_ff;
   logic signed [DEN_W-1:0] den_ff;
   logic                    v0_ff;

   logic [D_W-1:0]   mag_d;
   logic [DEN_W-1:0] mag_den;

   logic [REM_W-1:0] rem_ff [0:STEPS];
   logic [Q_W-1:0]   quo_ff [0:STEPS];
   logic [DEN_W-1:0] dvs_ff [0:STEPS];
   logic             neg_ff [0:STEPS];
   logic             flt_ff [0:STEPS];
   logic             vld_ff [0:STEPS];

   logic [Q_W-1:0]    q_fin;
   logic [NORM_W-1:0] norm_in;
   logic [NORM_W-1:0] norm_ff;
   logic              fault_ff;
   logic              out_valid_ff;

   // Stage 0: signed numerator and denominator.
   always_ff @(posedge clock) begin
      diff_ff <= (D_W'(raw) <<< 1) - D_W'(neg_ref) - D_W'(pos_ref);
      den_ff  <= DEN_W'(pos_ref) - DEN_W'(neg_ref);
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
   end

   // Stage 1: magnitudes; the dividend carries the rounding half.
   assign mag_d   = diff_ff[D_W-1] ? D_W'(-diff_ff) : D_W'(diff_ff);
   assign mag_den = den_ff[DEN_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);

   always_ff @(posedge clock) begin
      rem_ff[0] <= (REM_W'(mag_d) << (NORM_SHIFT + 1)) + REM_W'(mag_den);
      quo_ff[0] <= '0;
      dvs_ff[0] <= mag_den;
      neg_ff[0] <= diff_ff[D_W-1] ^ den_ff[DEN_W-1];
      flt_ff[0] <= (den_ff == '0);
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= v0_ff;
      end
   end

   // One quotient bit per stage, most significant first; the divisor is
   // twice the denominator magnitude.
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [REM_W-1:0] shifted;
      logic             ge;
      assign shifted = REM_W'(dvs_ff[k]) << (STEPS - k);
      assign ge      = (rem_ff[k] >= shifted);
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? (rem_ff[k] - shifted) : rem_ff[k];
         quo_ff[k+1] <= {quo_ff[k][Q_W-2:0], ge};
         dvs_ff[k+1] <= dvs_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         flt_ff[k+1] <= flt_ff[k];
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   // Sign and saturation.
   assign q_fin = quo_ff[STEPS];
   always_comb begin
      if (flt_ff[STEPS]) begin
         norm_in = '0;
      end else if (neg_ff[STEPS]) begin
         if (q_fin >= Q_W'(NORM_HALF)) begin
            norm_in = NORM_W'(NORM_HALF);
         end else begin
            norm_in = NORM_W'(0) - q_fin[NORM_W-1:0];
         end
      end else begin
         if (q_fin >= Q_W'(NORM_MAX)) begin
            norm_in = NORM_W'(NORM_MAX);
         end else begin
            norm_in = q_fin[NORM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      norm_ff  <= norm_in;
      fault_ff <= flt_ff[STEPS];
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[STEPS];
      end
   end

   assign norm      = norm_ff;
   assign fault     = fault_ff;
   assign out_valid = out_valid_ff;

endmodule
`default_nettype wire

@@ hdl/atc_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atc_cordic: pipelined vectoring CORDIC for atan2(y, x)
// One micro-rotation per stage, a quadrant pre-rotation in front, and a
// rounding and clamping stage at the end. The angle is in 1/128 degree.
// ----------------------------------------------------------------------------
module atc_cordic import atc_pkg::*; #(
   parameter int STAGES = DEF_ANGLE_STAGES,
   parameter int LIMIT  = PITCH_LIMIT,
   parameter int OUT_W  = PITCH_W
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   input  wire  signed [CIN_W-1:0] in_y,
   input  wire  signed [CIN_W-1:0] in_x,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] angle
);

   localparam int QW = ANG_W - ANGLE_DROP;
   localparam logic signed [QW-1:0]    LIM_P = QW'(LIMIT);
   localparam logic signed [QW-1:0]    LIM_N = -QW'(LIMIT);
   localparam logic signed [ANG_W-1:0] HALF_LSB = ANG_W'(2 ** (ANGLE_DROP - 1));

   logic signed [CORDIC_W-1:0] x_ff   [0:STAGES];
   logic signed [CORDIC_W-1:0] y_ff   [0:STAGES];
   logic signed [ANG_W-1:0]    ang_ff [0:STAGES];
   logic                       zero_ff[0:STAGES];
   logic                       vld_ff [0:STAGES];

   logic signed [CORDIC_W-1:0] xs, ys;
   logic signed [ANG_W-1:0]    rounded;
   logic signed [QW-1:0]       q;
   logic signed [QW-1:0]       q_clamp;
   logic signed [OUT_W-1:0]    angle_ff;
   logic                       out_valid_ff;

   assign xs = CORDIC_W'(in_x) <<< GAIN_SHIFT;
   assign ys = CORDIC_W'(in_y) <<< GAIN_SHIFT;

   // Pre-rotation by a quarter turn brings the vector into the right half plane.
   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
      if (!xs[CORDIC_W-1]) begin
         x_ff[0]   <= xs;
         y_ff[0]   <= ys;
         ang_ff[0] <= '0;
      end else if (!ys[CORDIC_W-1]) begin
         x_ff[0]   <= ys;
         y_ff[0]   <= -xs;
         ang_ff[0] <= ANG_W'(QUARTER_TURN);
      end else begin
         x_ff[0]   <= -ys;
         y_ff[0]   <= xs;
         ang_ff[0] <= -ANG_W'(QUARTER_TURN);
      end
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      localparam logic signed [ANG_W-1:0] ARC = arc_angle(i);
      always_ff @(posedge clock) begin
         if (!y_ff[i][CORDIC_W-1]) begin
            x_ff[i+1]   <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1]   <= y_ff[i] - (x_ff[i] >>> i);
            ang_ff[i+1] <= ang_ff[i] + ARC;
         end else begin
            x_ff[i+1]   <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1]   <= y_ff[i] + (x_ff[i] >>> i);
            ang_ff[i+1] <= ang_ff[i] - ARC;
         end
         zero_ff[i+1] <= zero_ff[i];
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   // Round to 1/128 degree and clamp.
   assign rounded = ang_ff[STAGES] + HALF_LSB;
   assign q       = QW'(rounded >>> ANGLE_DROP);

   always_comb begin
      if (zero_ff[STAGES]) begin
         q_clamp = '0;
      end else if (q > LIM_P) begin
         q_clamp = LIM_P;
      end else if (q < LIM_N) begin
         q_clamp = LIM_N;
      end else begin
         q_clamp = q;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= OUT_W'(q_clamp);
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[STAGES];
      end
   end

   assign angle     = angle_ff;
   assign out_valid = out_valid_ff;

endmodule
`default_nettype wire

@@ hdl/accel_tilt_calibrate_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_calibrate_top: accelerometer calibration and tilt angles
// Maps each raw axis to Q2.13 g with a two-point calibration and computes
// pitch and roll in 1/128 degree with pipelined CORDIC units.
// ----------------------------------------------------------------------------
// The block is a fully pipelined datapath that takes one sample transaction
// in every clock cycle while busy is low and returns exactly one result
// transaction for each, in order, after it has passed through the
// calibration divider, the square and square root, and the CORDIC units.
// The pipeline length is set by the one-bit-per-stage divider and root
// extractor and by the CORDIC stage count. A sample is taken at a rising
// edge where start is high and busy is low; busy is high only during reset.
// The result appears for exactly one cycle with rsp_strobe high, and the
// receiver cannot stall it, so it must capture every result as it comes.
// Calibration registers are written through the csr_ port and take effect for
// samples taken after the write; they should be changed only while no
// transaction is in flight. An axis whose two references are equal reads zero
// and raises rsp_cal_fault.
// ----------------------------------------------------------------------------
module accel_tilt_calibrate_top import atc_pkg::*; #(
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int ANGLE_STAGES = DEF_ANGLE_STAGES
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire  signed [SAMPLE_BITS-1:0] req_accel_x,
   input  wire  signed [SAMPLE_BITS-1:0] req_accel_y,
   input  wire  signed [SAMPLE_BITS-1:0] req_accel_z,
   output logic                      rsp_strobe,
   output logic signed [NORM_W-1:0]  rsp_norm_x,
   output logic signed [NORM_W-1:0]  rsp_norm_y,
   output logic signed [NORM_W-1:0]  rsp_norm_z,
   output logic signed [PITCH_W-1:0] rsp_pitch_angle,
   output logic signed [ROLL_W-1:0]  rsp_roll_angle,
   output logic                      rsp_cal_fault,
   input  wire                       csr_we,
   input  wire  [CSR_INDEX_W-1:0]    csr_index,
   input  wire  [SAMPLE_BITS-1:0]    csr_wdata
);

   // References are kept wide enough for their reset values even when the
   // samples are narrower.
   localparam int REF_W      = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
   localparam int RUN_STAGES = (ANGLE_STAGES < ARC_LEN) ? ANGLE_STAGES : ARC_LEN;
   localparam int CORDIC_LAT = RUN_STAGES + 2;
   localparam int TOTAL_LAT  = NORM_LAT + SQ_LAT + CORDIC_LAT;
   localparam logic signed [REF_W-1:0] NEG_RST = REF_W'(REF_NEG_RESET);
   localparam logic signed [REF_W-1:0] POS_RST = REF_W'(REF_POS_RESET);

   logic accept;

   logic signed [REF_W-1:0] x_neg_ff, x_pos_ff, y_neg_ff, y_pos_ff, z_neg_ff, z_pos_ff;
   logic signed [REF_W-1:0] wval;

   logic                     nx_valid, ny_valid, nz_valid;
   logic signed [NORM_W-1:0] nx, ny, nz;
   logic                     fx, fy, fz;
   norm_set_type             nset;

   // Magnitude path registers.
   logic [SQ_W-1:0] sq_y_ff, sq_z_ff, sum_ff;
   logic [SQ_W-1:0] rem_ff [0:SQRT_STEPS];
   logic [SQ_W-1:0] res_ff [0:SQRT_STEPS];
   logic            sq_vld_ff [0:SQ_LAT-1];
   norm_set_type    nd_ff [0:SQ_LAT-1];
   norm_set_type    od_ff [0:CORDIC_LAT-1];

   logic signed [CIN_W-1:0] roll_y, roll_x, pitch_y, pitch_x;
   logic                    pitch_valid, roll_valid;
   logic signed [PITCH_W-1:0] pitch;
   logic signed [ROLL_W-1:0]  roll;

   assign busy   = reset;
   assign accept = start && !busy;

   // ------------------------------------------------------------------
   // Calibration registers. Writes to indexes past the list are ignored.
   // ------------------------------------------------------------------
   assign wval = REF_W'($signed(csr_wdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         x_neg_ff <= NEG_RST;
         x_pos_ff <= POS_RST;
         y_neg_ff <= NEG_RST;
         y_pos_ff <= POS_RST;
         z_neg_ff <= NEG_RST;
         z_pos_ff <= POS_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_X_NEG: x_neg_ff <= wval;
            CSR_X_POS: x_pos_ff <= wval;
            CSR_Y_NEG: y_neg_ff <= wval;
            CSR_Y_POS: y_pos_ff <= wval;
            CSR_Z_NEG: z_neg_ff <= wval;
            CSR_Z_POS: z_pos_ff <= wval;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Per-axis calibration dividers. All three run in lock step.
   // ------------------------------------------------------------------
   atc_norm #(.REF_W(REF_W)) u_norm_x (
      .clock(clock), .reset(reset), .in_valid(accept),
      .raw(REF_W'(req_accel_x)), .neg_ref(x_neg_ff), .pos_ref(x_pos_ff),
      .out_valid(nx_valid), .norm(nx), .fault(fx)
   );

   atc_norm #(.REF_W(REF_W)) u_norm_y (
      .clock(clock), .reset(reset), .in_valid(accept),
      .raw(REF_W'(req_accel_y)), .neg_ref(y_neg_ff), .pos_ref(y_pos_ff),
      .out_valid(ny_valid), .norm(ny), .fault(fy)
   );

   atc_norm #(.REF_W(REF_W)) u_norm_z (
      .clock(clock), .reset(reset), .in_valid(accept),
      .raw(REF_W'(req_accel_z)), .neg_ref(z_neg_ff), .pos_ref(z_pos_ff),
      .out_valid(nz_valid), .norm(nz), .fault(fz)
   );

   assign nset = '{x: nx, y: ny, z: nz, fault: fx || fy || fz};

   // ------------------------------------------------------------------
   // Magnitude of the y-z projection: square, sum, then a bit-per-stage
   // integer square root (floor).
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      sq_y_ff <= SQ_W'(SQ_W'(ny) * SQ_W'(ny));
      sq_z_ff <= SQ_W'(SQ_W'(nz) * SQ_W'(nz));
      sum_ff  <= sq_y_ff + sq_z_ff;
   end

   assign rem_ff[0] = sum_ff;
   assign res_ff[0] = '0;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [SQ_W-1:0] trial;
      logic            ge;
      assign trial = res_ff[k] + BIT;
      assign ge    = (rem_ff[k] >= trial);
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? (rem_ff[k] - trial) : rem_ff[k];
         res_ff[k+1] <= ge ? ((res_ff[k] >> 1) + BIT) : (res_ff[k] >> 1);
      end
   end

   // Calibrated values and valid bits ride alongside the magnitude path.
   always_ff @(posedge clock) begin
      nd_ff[0] <= nset;
      for (int s = 1; s < SQ_LAT; s++) begin
         nd_ff[s] <= nd_ff[s-1];
      end
      if (reset) begin
         for (int s = 0; s < SQ_LAT; s++) begin
            sq_vld_ff[s] <= 1'b0;
         end
      end else begin
         sq_vld_ff[0] <= nx_valid;
         for (int s = 1; s < SQ_LAT; s++) begin
            sq_vld_ff[s] <= sq_vld_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Angle units. Pitch and roll start together so they finish together.
   // ------------------------------------------------------------------
   assign pitch_y = CIN_W'(nd_ff[SQ_LAT-1].y);
   assign pitch_x = CIN_W'(nd_ff[SQ_LAT-1].z);
   assign roll_y  = CIN_W'(0) - CIN_W'(nd_ff[SQ_LAT-1].x);
   assign roll_x  = CIN_W'({1'b0, res_ff[SQRT_STEPS][NORM_W-1:0]});

   atc_cordic #(.STAGES(RUN_STAGES), .LIMIT(PITCH_LIMIT), .OUT_W(PITCH_W)) u_pitch (
      .clock(clock), .reset(reset), .in_valid(sq_vld_ff[SQ_LAT-1]),
      .in_y(pitch_y), .in_x(pitch_x), .out_valid(pitch_valid), .angle(pitch)
   );

   atc_cordic #(.STAGES(RUN_STAGES), .LIMIT(ROLL_LIMIT), .OUT_W(ROLL_W)) u_roll (
      .clock(clock), .reset(reset), .in_valid(sq_vld_ff[SQ_LAT-1]),
      .in_y(roll_y), .in_x(roll_x), .out_valid(roll_valid), .angle(roll)
   );

   always_ff @(posedge clock) begin
      od_ff[0] <= nd_ff[SQ_LAT-1];
      for (int s = 1; s < CORDIC_LAT; s++) begin
         od_ff[s] <= od_ff[s-1];
      end
   end

   // ------------------------------------------------------------------
   // Result transaction.
   // ------------------------------------------------------------------
   assign rsp_strobe      = roll_valid;
   assign rsp_norm_x      = od_ff[CORDIC_LAT-1].x;
   assign rsp_norm_y      = od_ff[CORDIC_LAT-1].y;
   assign rsp_norm_z      = od_ff[CORDIC_LAT-1].z;
   assign rsp_cal_fault   = od_ff[CORDIC_LAT-1].fault;
   assign rsp_pitch_angle = pitch;
   assign rsp_roll_angle  = roll;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // Every accepted transaction comes out after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##TOTAL_LAT rsp_strobe)
      else $error("result missing after pipeline latency");

   // No result appears without a transaction taken in at the right time.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, TOTAL_LAT))
      else $error("result without matching transaction");

   // The three calibration dividers stay in step.
   a_norm_aligned: assert property (@(posedge clock) disable iff (reset)
      (nx_valid == ny_valid) && (ny_valid == nz_valid))
      else $error("calibration dividers out of step");

   // The two angle units stay in step.
   a_units_aligned: assert property (@(posedge clock) disable iff (reset)
      pitch_valid == roll_valid)
      else $error("pitch and roll pipelines out of step");

   // A zero y-z projection gives a zero pitch.
   a_pitch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_norm_y == '0 && rsp_norm_z == '0) |-> rsp_pitch_angle == '0)
      else $error("pitch of a zero vector is not zero");

endmodule
`default_nettype wire
